@@ sv/lsws_pkg.sv @@
// Package: shared types and constants of the location stack with search.
`timescale 1ns / 1ps

package lsws_pkg;

    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_COORD_BITS  = 8;
    localparam int DIR_BITS        = 3;
    localparam int ACT_BITS        = 2;
    localparam int STATUS_BITS     = 2;

    typedef enum logic [ACT_BITS-1:0] {
        ACT_PUSH   = 2'd0,
        ACT_POP    = 2'd1,
        ACT_SEARCH = 2'd2
    } t_action;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic    accept;     // capture search key, clear found, take status
        logic    push;       // write entry, bump count, new top
        logic    pop;        // drop count, read the entry under the top
        logic    srch_start; // read slot 0
        logic    srch_step;  // read next slot
        logic    pop_load;   // top from read data
        logic    set_found;
        logic    out_load;   // move result into the output register
        t_status status;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic full;
        logic empty;
        logic match;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

@@ sv/lsws_in_if.sv @@
// Interface: input channel carrying one stack operation.
`timescale 1ns / 1ps

interface lsws_in_if #(
    parameter int COORD_BITS = 8
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic [COORD_BITS-1:0] loc_row;
    logic [COORD_BITS-1:0] loc_col;
    logic [2:0]            loc_dir;

    modport source (output valid, action, loc_row, loc_col, loc_dir, input ready);
    modport sink   (input valid, action, loc_row, loc_col, loc_dir, output ready);
endinterface

@@ sv/lsws_out_if.sv @@
// Interface: output channel carrying one result.
`timescale 1ns / 1ps

interface lsws_out_if #(
    parameter int COORD_BITS = 8,
    parameter int CNT_BITS   = 9
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] top_row;
    logic [COORD_BITS-1:0] top_col;
    logic [2:0]            top_dir;
    logic                  is_empty;
    logic                  found;
    logic [CNT_BITS-1:0]   entry_count;
    logic [1:0]            status;

    modport source (output valid, top_row, top_col, top_dir, is_empty, found,
                    entry_count, status, input ready);
    modport sink   (input valid, top_row, top_col, top_dir, is_empty, found,
                    entry_count, status, output ready);
endinterface

@@ sv/lsws_ctrl.sv @@
// Controller: state machine sequencing push, pop and search operations.
`timescale 1ns / 1ps

module lsws_ctrl import lsws_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [ACT_BITS-1:0] i_action,
    input  t_sts                i_sts,
    output t_cmd                o_cmd,
    output logic                o_in_ready
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_POP_LD = 4'b0010,
        S_SRCH   = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_OK;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_DONE;
                    case (i_action)
                        ACT_PUSH: begin
                            if (i_sts.full) begin
                                o_cmd.status = ST_OVERFLOW;
                            end else begin
                                o_cmd.push = 1'b1;
                            end
                        end
                        ACT_POP: begin
                            if (i_sts.empty) begin
                                o_cmd.status = ST_UNDERFLOW;
                            end else begin
                                o_cmd.pop = 1'b1;
                                n_state   = S_POP_LD;
                            end
                        end
                        ACT_SEARCH: begin
                            if (!i_sts.empty) begin
                                o_cmd.srch_start = 1'b1;
                                n_state          = S_SRCH;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP_LD: begin
                o_cmd.pop_load = 1'b1;
                n_state        = S_DONE;
            end
            S_SRCH: begin
                // read data holds the slot just below the scan index
                if (i_sts.match) begin
                    o_cmd.set_found = 1'b1;
                    n_state         = S_DONE;
                end else if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.srch_step = 1'b1;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ sv/lsws_datapath.sv @@
// Datapath: entry memory, fill count, top cache, search scan and result register.
`timescale 1ns / 1ps

module lsws_datapath import lsws_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int COORD_BITS  = DEF_COORD_BITS,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
    localparam int CW = $clog2(STACK_DEPTH + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    input  logic [COORD_BITS-1:0] i_row,
    input  logic [COORD_BITS-1:0] i_col,
    input  logic [DIR_BITS-1:0]   i_dir,
    output t_sts                  o_sts,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [COORD_BITS-1:0] o_top_row,
    output logic [COORD_BITS-1:0] o_top_col,
    output logic [DIR_BITS-1:0]   o_top_dir,
    output logic                  o_is_empty,
    output logic                  o_found,
    output logic [CW-1:0]         o_entry_count,
    output logic [STATUS_BITS-1:0] o_status
);

    localparam int EW = 2 * COORD_BITS + DIR_BITS;

    logic [EW-1:0]         r_mem [STACK_DEPTH];
    logic [EW-1:0]         r_rd_data;
    logic [AW-1:0]         n_rd_addr;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic [CW-1:0]         count_m2;
    logic [COORD_BITS-1:0] r_key_row;
    logic [COORD_BITS-1:0] r_key_col;
    logic [EW-1:0]         r_top;
    logic                  r_found;
    t_status               r_status;
    logic                  r_out_valid;
    logic                  empty;

    assign empty    = (r_count == '0);
    assign count_m2 = r_count - CW'(2);

    always_comb begin
        if (i_cmd.pop) begin
            n_rd_addr = count_m2[AW-1:0];
        end else if (i_cmd.srch_start) begin
            n_rd_addr = '0;
        end else begin
            n_rd_addr = r_idx[AW-1:0];
        end
    end

    assign o_sts.full      = (r_count == CW'(STACK_DEPTH));
    assign o_sts.empty     = empty;
    assign o_sts.match     = (r_rd_data[EW-1 -: COORD_BITS] == r_key_row) &&
                             (r_rd_data[DIR_BITS +: COORD_BITS] == r_key_col);
    assign o_sts.scan_done = (r_idx == r_count);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[n_rd_addr];
        if (i_cmd.push) begin
            r_mem[r_count[AW-1:0]] <= {i_row, i_col, i_dir};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CW'(1);
        end else if (i_cmd.pop) begin
            r_count <= r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_key_row <= i_row;
            r_key_col <= i_col;
            r_status  <= i_cmd.status;
        end
        if (i_cmd.accept) begin
            r_found <= 1'b0;
        end else if (i_cmd.set_found) begin
            r_found <= 1'b1;
        end
        if (i_cmd.srch_start) begin
            r_idx <= CW'(1);
        end else if (i_cmd.srch_step) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.push) begin
            r_top <= {i_row, i_col, i_dir};
        end else if (i_cmd.pop_load) begin
            r_top <= r_rd_data;
        end
    end

    // result register; top fields read as zero on an empty stack
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_top_row     <= empty ? '0 : r_top[EW-1 -: COORD_BITS];
            o_top_col     <= empty ? '0 : r_top[DIR_BITS +: COORD_BITS];
            o_top_dir     <= empty ? '0 : r_top[DIR_BITS-1:0];
            o_is_empty    <= empty;
            o_found       <= r_found;
            o_entry_count <= r_count;
            o_status      <= r_status;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ sv/location_stack_with_search_top.sv @@
// Top level: location stack with membership search.
`timescale 1ns / 1ps

// One operation is taken at a time; each yields one result into an output
// register, and the next operation is taken while that result waits. A push,
// a rejected pop, an empty search or an unknown action code goes from the
// transfer through S_DONE into that register; a pop first passes S_POP_LD,
// since the new top is read back from the entry memory. A search walks the
// memory from the bottom, one entry per cycle through its single read port,
// and stops at the first match; it examines at most the fill count of
// entries (up to STACK_DEPTH). The memory needs no clearing; only data from
// slots below the fill count reaches a result.
module location_stack_with_search_top import lsws_pkg::*; #(
    parameter int STACK_DEPTH = DEF_STACK_DEPTH,
    parameter int COORD_BITS  = DEF_COORD_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lsws_in_if.sink       i_in,
    lsws_out_if.source    o_out
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_cmd cmd;
    t_sts sts;

    lsws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_action   (i_in.action),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_ready (i_in.ready)
    );

    lsws_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_row         (i_in.loc_row),
        .i_col         (i_in.loc_col),
        .i_dir         (i_in.loc_dir),
        .o_sts         (sts),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_top_row     (o_out.top_row),
        .o_top_col     (o_out.top_col),
        .o_top_dir     (o_out.top_dir),
        .o_is_empty    (o_out.is_empty),
        .o_found       (o_out.found),
        .o_entry_count (o_out.entry_count),
        .o_status      (o_out.status)
    );

    // one operation in flight: no transfer right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input taken while an operation is in flight");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.is_empty == (o_out.entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.status == ST_OVERFLOW)) |->
            (o_out.entry_count == CW'(STACK_DEPTH)))
        else $error("overflow reported on a stack that is not full");

    a_found_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.found) |-> (!o_out.is_empty && (o_out.status == ST_OK)))
        else $error("match reported on an empty stack or with bad status");

    a_srch_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.srch_step |-> !sts.scan_done)
        else $error("search scan ran past the fill count");

endmodule

@@ tb/location_stack_with_search_top_test.sv @@
// Testbench: random and directed push/pop/search traffic checked against a stack predictor.
`timescale 1ns / 1ps

module location_stack_with_search_top_test;
    import lsws_pkg::*;

    localparam int STACK_DEPTH   = DEF_STACK_DEPTH;
    localparam int COORD_BITS    = DEF_COORD_BITS;
    localparam int CNT_BITS      = $clog2(STACK_DEPTH + 1);
    localparam int RANDOM_OPS    = 1830;
    // watchdog limit; must cover a full-depth search plus worst sender gap and output stall
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 300;

    // action code outside the defined set
    localparam logic [ACT_BITS-1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [COORD_BITS-1:0] row;
        logic [COORD_BITS-1:0] col;
        logic [DIR_BITS-1:0]   dir;
    } t_loc;

    typedef struct packed {
        logic [COORD_BITS-1:0]  row;
        logic [COORD_BITS-1:0]  col;
        logic [DIR_BITS-1:0]    dir;
        logic                   empty;
        logic                   found;
        logic [CNT_BITS-1:0]    count;
        logic [STATUS_BITS-1:0] status;
    } t_result;

    typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} t_mode;

    // Tracks the stack contents and the results still owed by the block.
    class stack_tracker;
        t_loc        slots [STACK_DEPTH];
        int unsigned fill;
        t_result     owed_results [$];
        int unsigned errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void take_op(logic [ACT_BITS-1:0] act, t_loc loc);
            t_result r;
            int unsigned i;
            r = '0;
            r.status = ST_OK;
            case (act)
                ACT_PUSH: begin
                    if (fill == STACK_DEPTH) begin
                        r.status = ST_OVERFLOW;
                    end else begin
                        slots[fill] = loc;
                        fill++;
                    end
                end
                ACT_POP: begin
                    if (fill == 0) r.status = ST_UNDERFLOW;
                    else fill--;
                end
                ACT_SEARCH: begin
                    // direction takes no part in the match
                    for (i = 0; i < fill; i++) begin
                        if (slots[i].row == loc.row && slots[i].col == loc.col) r.found = 1'b1;
                    end
                end
                default: ;
            endcase
            if (fill > 0) begin
                r.row = slots[fill-1].row;
                r.col = slots[fill-1].col;
                r.dir = slots[fill-1].dir;
            end
            r.empty = (fill == 0);
            r.count = CNT_BITS'(fill);
            owed_results.push_back(r);
        endfunction

        function int field_diff(string name, int unsigned want, int unsigned got);
            if (want == got) return 0;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            return 1;
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (owed_results.size() == 0) begin
                $display("%0t: result with none expected: top %0d/%0d/%0d count %0d status %0d",
                         $time, got.row, got.col, got.dir, got.count, got.status);
                errors++;
                return;
            end
            want = owed_results.pop_front();
            errors += field_diff("top_row", want.row, got.row);
            errors += field_diff("top_col", want.col, got.col);
            errors += field_diff("top_dir", want.dir, got.dir);
            errors += field_diff("is_empty", want.empty, got.empty);
            errors += field_diff("found", want.found, got.found);
            errors += field_diff("entry_count", want.count, got.count);
            errors += field_diff("status", want.status, got.status);
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    bit   no_idle = 1'b0;
    int   idle_cycles = 0;
    t_result      seen;
    stack_tracker tracker;

    lsws_in_if  #(.COORD_BITS(COORD_BITS)) in_ch ();
    lsws_out_if #(.COORD_BITS(COORD_BITS), .CNT_BITS(CNT_BITS)) out_ch ();

    location_stack_with_search_top #(
        .STACK_DEPTH(STACK_DEPTH),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_op(input logic [ACT_BITS-1:0] act, input logic [COORD_BITS-1:0] row,
                           input logic [COORD_BITS-1:0] col, input logic [DIR_BITS-1:0] dir);
        int gap;
        t_loc loc;
        gap = pick_gap();
        loc.row = row;
        loc.col = col;
        loc.dir = dir;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.action  <= act;
        in_ch.loc_row <= row;
        in_ch.loc_col <= col;
        in_ch.loc_dir <= dir;
        in_ch.valid   <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        tracker.take_op(act, loc);
    endtask

    // hold the sender off until every owed result has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (tracker.owed_results.size() != 0);
    endtask

    // result side back-pressure
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            stall = pick_gap();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    // result checking and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen = '{out_ch.top_row, out_ch.top_col, out_ch.top_dir, out_ch.is_empty,
                     out_ch.found, out_ch.entry_count, out_ch.status};
            tracker.check_result(seen);
        end
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("location_stack_with_search_top_test NOT OK");
            $finish;
        end
    end

    initial begin
        int          sent;
        int          phases;
        int          tail;
        int          span;
        bit          phase_done;
        int          r;
        int unsigned idx;
        t_mode       mode;
        logic [ACT_BITS-1:0] act;
        t_loc        loc;

        tracker = new();
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.action  <= ACT_PUSH;
        in_ch.loc_row <= '0;
        in_ch.loc_col <= '0;
        in_ch.loc_dir <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty-stack corner cases, field extremes, every action
        send_op(ACT_POP,     8'd0,   8'd0,   3'd0);
        send_op(ACT_SEARCH,  8'd0,   8'd0,   3'd0);
        send_op(ACT_UNKNOWN, 8'd0,   8'd0,   3'd0);
        send_op(ACT_PUSH,    8'd0,   8'd0,   3'd0);
        send_op(ACT_PUSH,    8'd255, 8'd255, 3'd7);
        send_op(ACT_PUSH,    8'd255, 8'd0,   3'd4);
        send_op(ACT_PUSH,    8'd0,   8'd255, 3'd5);
        send_op(ACT_SEARCH,  8'd255, 8'd255, 3'd0);
        send_op(ACT_SEARCH,  8'd0,   8'd0,   3'd7);
        send_op(ACT_SEARCH,  8'd255, 8'd254, 3'd1);
        send_op(ACT_SEARCH,  8'd0,   8'd255, 3'd2);
        send_op(ACT_UNKNOWN, 8'd255, 8'd255, 3'd7);
        send_op(ACT_POP,     8'd255, 8'd255, 3'd7);
        send_op(ACT_POP,     8'd0,   8'd0,   3'd0);
        send_op(ACT_SEARCH,  8'd255, 8'd0,   3'd0);
        send_op(ACT_POP,     8'd0,   8'd0,   3'd0);
        send_op(ACT_POP,     8'd0,   8'd0,   3'd0);
        send_op(ACT_POP,     8'd0,   8'd0,   3'd0);
        send_op(ACT_PUSH,    8'd170, 8'd85,  3'd6);
        send_op(ACT_PUSH,    8'd85,  8'd170, 3'd3);
        send_op(ACT_SEARCH,  8'd85,  8'd170, 3'd0);
        send_op(ACT_SEARCH,  8'd170, 8'd170, 3'd0);
        send_op(ACT_UNKNOWN, 8'd85,  8'd85,  3'd2);
        wait_drained();

        // phases: fill to full and overflow, drain to empty and underflow, mixed traffic
        sent   = 0;
        phases = 0;
        mode   = MODE_FILL;
        while (sent < RANDOM_OPS) begin
            phase_done = 1'b0;
            tail       = $urandom_range(2, 8);
            span       = $urandom_range(40, 120);
            no_idle    = ($urandom_range(3) == 0);
            while (!phase_done && sent < RANDOM_OPS) begin
                r = $urandom_range(99);
                case (mode)
                    MODE_FILL:  act = r < 75 ? ACT_PUSH : r < 85 ? ACT_POP :
                                      r < 97 ? ACT_SEARCH : ACT_UNKNOWN;
                    MODE_DRAIN: act = r < 75 ? ACT_POP : r < 85 ? ACT_PUSH :
                                      r < 97 ? ACT_SEARCH : ACT_UNKNOWN;
                    default:    act = r < 35 ? ACT_PUSH : r < 70 ? ACT_POP :
                                      r < 95 ? ACT_SEARCH : ACT_UNKNOWN;
                endcase
                // a narrow coordinate range now and then gives duplicate entries
                if ($urandom_range(4) == 0) begin
                    loc.row = COORD_BITS'($urandom_range(3));
                    loc.col = COORD_BITS'($urandom_range(3));
                end else begin
                    loc.row = COORD_BITS'($urandom_range(255));
                    loc.col = COORD_BITS'($urandom_range(255));
                end
                loc.dir = DIR_BITS'($urandom_range(7));
                if (act == ACT_SEARCH && tracker.fill > 0 && $urandom_range(99) < 60) begin
                    idx     = $urandom_range(tracker.fill - 1);
                    loc.row = tracker.slots[idx].row;
                    loc.col = tracker.slots[idx].col;
                    if ($urandom_range(4) == 0) loc.col = loc.col ^ COORD_BITS'(1);
                end
                send_op(act, loc.row, loc.col, loc.dir);
                sent++;
                case (mode)
                    MODE_FILL: begin
                        if (tracker.fill == STACK_DEPTH) tail--;
                        phase_done = (tail == 0);
                    end
                    MODE_DRAIN: begin
                        if (tracker.fill == 0) tail--;
                        phase_done = (tail == 0);
                    end
                    default: begin
                        span--;
                        phase_done = (span == 0);
                    end
                endcase
            end
            phases++;
            if (phases == 1) mode = MODE_DRAIN;
            else mode = t_mode'($urandom_range(2));
            if (phases == 1 || $urandom_range(1) == 0) wait_drained();
        end

        no_idle = 1'b0;
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("location_stack_with_search_top_test OK");
        end else begin
            $display("location_stack_with_search_top_test NOT OK");
        end
        $finish;
    end

endmodule
